### rtl/point_segment_distance_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the point segment distance core.
// Simulation gets concurrent assertions; synthesis gets empty bodies.
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_CORE_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge out of reset.
`define PSD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// A condition that must never occur.
`define PSD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define PSD_ASSERT(lbl, clk, rstn, prop)
`define PSD_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

### rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Types, widths and helpers shared by the point segment distance core.
// ----------------------------------------------------------------------------
package psd_pkg;

  // Width of the input coordinate fields.
  localparam int COORD_BITS = 16;
  // Working coordinate width after saturation.
  localparam int CW        = 16;
  localparam int DW        = CW + 1;
  localparam int DIVW      = 53;
  localparam int QW        = 17;
  localparam int DIV_CELLS = QW;
  localparam int SQW       = 51;
  localparam int SQ_CELLS  = 25;
  localparam int SQ_TOP    = 2 * (SQ_CELLS - 1);
  localparam int NW        = 24;
  localparam int DISTW     = 25;

  typedef enum logic [1:0] {
    CASE_DEGEN    = 2'd0,
    CASE_START    = 2'd1,
    CASE_END      = 2'd2,
    CASE_INTERIOR = 2'd3
  } case_e;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    case_e                code;
  } ctx_t;

  // Word that travels down the divider chain.
  typedef struct packed {
    logic [DIVW-1:0] rem;
    logic [DIVW-1:0] ds;
    logic [QW-1:0]   q;
    ctx_t            ctx;
  } div_t;

  typedef struct packed {
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    case_e                code;
  } res_t;

  // Word that travels down the square root chain.
  typedef struct packed {
    logic [SQW-1:0] n;
    logic [SQW-1:0] root;
    logic [SQW-1:0] bitv;
    res_t           res;
  } sqr_t;

  // Clamp an input coordinate to the signed 16 bit range.
  function automatic logic signed [CW-1:0] sat_coord(input logic [COORD_BITS-1:0] raw);
    logic signed [32:0] w;
    w = 33'($signed(raw));
    if (w > 33'sd32767) begin
      w = 33'sd32767;
    end else if (w < -33'sd32768) begin
      w = -33'sd32768;
    end
    return w[CW-1:0];
  endfunction

endpackage

### rtl/psd_if.sv
// ----------------------------------------------------------------------------
// psd_in_if / psd_out_if
// Valid/ready channels for query words and result words.
// ----------------------------------------------------------------------------
interface psd_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [psd_pkg::COORD_BITS-1:0]   start_x;
  logic signed [psd_pkg::COORD_BITS-1:0]   start_y;
  logic signed [psd_pkg::COORD_BITS-1:0]   end_x;
  logic signed [psd_pkg::COORD_BITS-1:0]   end_y;
  logic signed [psd_pkg::COORD_BITS-1:0]   point_x;
  logic signed [psd_pkg::COORD_BITS-1:0]   point_y;

  modport source (output valid, start_x, start_y, end_x, end_y, point_x, point_y,
                  input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, point_x, point_y,
                  output ready);
endinterface

interface psd_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [psd_pkg::NW-1:0]   nearest_x;
  logic signed [psd_pkg::NW-1:0]   nearest_y;
  logic [psd_pkg::DISTW-1:0]       distance;
  logic [1:0]                      case_code;

  modport source (output valid, nearest_x, nearest_y, distance, case_code,
                  input ready);
  modport sink   (input valid, nearest_x, nearest_y, distance, case_code,
                  output ready);
endinterface

### rtl/psd_div_cell.sv
// ----------------------------------------------------------------------------
// psd_div_cell
// One restoring division step: yields one quotient bit per cell.
// ----------------------------------------------------------------------------
`include "point_segment_distance_core_macros.svh"

module psd_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  psd_pkg::div_t  in_word_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output psd_pkg::div_t  out_word_o
);

  logic          valid_q;
  psd_pkg::div_t word_q, word_d;
  logic          ge;

  assign in_ready_o = !valid_q || out_ready_i;

  // Compare against the shifted divisor and subtract when it fits.
  always_comb begin
    ge          = in_word_i.rem >= in_word_i.ds;
    word_d      = in_word_i;
    word_d.rem  = ge ? (in_word_i.rem - in_word_i.ds) : in_word_i.rem;
    word_d.ds   = in_word_i.ds >> 1;
    word_d.q    = {in_word_i.q[psd_pkg::QW-2:0], ge};
  end

  // Valid flag of this cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  // The partial remainder always stays below twice the divisor step.
  `PSD_ASSERT(a_rem_bound, clk_i, rst_ni, in_valid_i |-> (in_word_i.rem < {in_word_i.ds, 1'b0}))

endmodule

### rtl/psd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// psd_sqrt_cell
// One digit step of the integer square root: one result bit per cell.
// ----------------------------------------------------------------------------
`include "point_segment_distance_core_macros.svh"

module psd_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  psd_pkg::sqr_t  in_word_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output psd_pkg::sqr_t  out_word_o
);

  logic                      valid_q;
  psd_pkg::sqr_t             word_q, word_d;
  logic [psd_pkg::SQW-1:0]   trial;
  logic                      ge;

  assign in_ready_o = !valid_q || out_ready_i;

  // Try root plus the current bit against the remaining radicand.
  always_comb begin
    trial       = in_word_i.root + in_word_i.bitv;
    ge          = in_word_i.n >= trial;
    word_d      = in_word_i;
    word_d.n    = ge ? (in_word_i.n - trial) : in_word_i.n;
    word_d.root = ge ? ((in_word_i.root >> 1) + in_word_i.bitv) : (in_word_i.root >> 1);
    word_d.bitv = in_word_i.bitv >> 2;
  end

  // Valid flag of this cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  // The probe bit is a single power of four or already spent.
  `PSD_ASSERT_NEVER(a_bit_onehot, clk_i, rst_ni, valid_q && !$onehot0(word_q.bitv))

endmodule

### rtl/point_segment_distance_core.sv
// ----------------------------------------------------------------------------
// point_segment_distance_core
// Nearest point on a segment and distance to it, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  in_i    | in  | start_x/y, end_x/y, point_x/y
//  out_o   | out | nearest_x/y, distance, case_code
//
// A word is accepted every cycle while out_o is not stalled. Words pass
// through three setup stages, 17 divider cells, five stages for the nearest
// point and the squared error, and 25 square root cells.
// Reset clears only the valid flags of the stages.
// Each stage holds its word when the next one is full and stalled, so a
// stalled output fills the chain from the end before in_i.ready falls.
// ----------------------------------------------------------------------------
`include "point_segment_distance_core_macros.svh"

module point_segment_distance_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  psd_in_if.sink   in_i,
  psd_out_if.source out_o
);

  localparam int DC = psd_pkg::DIV_CELLS;
  localparam int SC = psd_pkg::SQ_CELLS;

  logic r1, r2, r3, r4, r5, r6, r7, r8;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;

  psd_pkg::ctx_t c1_q, c1_d, c2_q, c3_q, c4_q, c5_q;
  logic signed [psd_pkg::DW-1:0] rx0_q, ry0_q;
  logic signed [33:0] mdx_q, mdy_q, mpx_q, mpy_q;
  logic signed [34:0] len2_q, dot_q;
  logic signed [34:0] prx_q, pry_q;
  logic signed [35:0] sumx, sumy;
  logic signed [25:0] nxf_q, nyf_q;
  logic signed [26:0] rx_q, ry_q;
  logic signed [53:0] sqx_q, sqy_q;
  logic [49:0] sq_q;
  psd_pkg::res_t res6_q, res7_q, res8_q;

  logic          div_v [DC+1];
  logic          div_r [DC+1];
  psd_pkg::div_t div_w [DC+1];
  logic          sq_v  [SC+1];
  logic          sq_r  [SC+1];
  psd_pkg::sqr_t sq_w  [SC+1];

  // Ready chain of the setup and middle stages.
  assign r1 = !v1_q || r2;
  assign r2 = !v2_q || r3;
  assign r3 = !v3_q || div_r[0];
  assign r4 = !v4_q || r5;
  assign r5 = !v5_q || r6;
  assign r6 = !v6_q || r7;
  assign r7 = !v7_q || r8;
  assign r8 = !v8_q || sq_r[0];
  assign in_i.ready = r1;

  // Valid flags of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_i.valid;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= div_v[DC];
      if (r5) v5_q <= v4_q;
      if (r6) v6_q <= v5_q;
      if (r7) v7_q <= v6_q;
      if (r8) v8_q <= v7_q;
    end
  end

  // Stage one: saturate the coordinates and form the differences.
  logic signed [psd_pkg::CW-1:0] ex_s, ey_s;
  always_comb begin
    c1_d      = '0;
    c1_d.sx   = psd_pkg::sat_coord(in_i.start_x);
    c1_d.sy   = psd_pkg::sat_coord(in_i.start_y);
    c1_d.px   = psd_pkg::sat_coord(in_i.point_x);
    c1_d.py   = psd_pkg::sat_coord(in_i.point_y);
    ex_s      = psd_pkg::sat_coord(in_i.end_x);
    ey_s      = psd_pkg::sat_coord(in_i.end_y);
    c1_d.dx   = psd_pkg::DW'(ex_s) - psd_pkg::DW'(c1_d.sx);
    c1_d.dy   = psd_pkg::DW'(ey_s) - psd_pkg::DW'(c1_d.sy);
    c1_d.code = psd_pkg::CASE_DEGEN;
  end

  always_ff @(posedge clk_i) begin
    if (r1) begin
      c1_q  <= c1_d;
      rx0_q <= psd_pkg::DW'(c1_d.px) - psd_pkg::DW'(c1_d.sx);
      ry0_q <= psd_pkg::DW'(c1_d.py) - psd_pkg::DW'(c1_d.sy);
    end
  end

  // Stage two: the four products of the projection.
  always_ff @(posedge clk_i) begin
    if (r2) begin
      c2_q  <= c1_q;
      mdx_q <= c1_q.dx * c1_q.dx;
      mdy_q <= c1_q.dy * c1_q.dy;
      mpx_q <= rx0_q * c1_q.dx;
      mpy_q <= ry0_q * c1_q.dy;
    end
  end

  // Stage three: squared length and dot product.
  always_ff @(posedge clk_i) begin
    if (r3) begin
      c3_q   <= c2_q;
      len2_q <= 35'(mdx_q) + 35'(mdy_q);
      dot_q  <= 35'(mpx_q) + 35'(mpy_q);
    end
  end

  // Branch choice and divider operands; clamped cases divide to 0 or 1.
  always_comb begin
    div_w[0]     = '0;
    div_w[0].ctx = c3_q;
    if (len2_q == '0) begin
      div_w[0].ctx.code = psd_pkg::CASE_DEGEN;
      div_w[0].rem      = '0;
      div_w[0].ds       = psd_pkg::DIVW'(1) << (psd_pkg::QW - 1);
    end else if (dot_q < 0) begin
      div_w[0].ctx.code = psd_pkg::CASE_START;
      div_w[0].rem      = '0;
      div_w[0].ds       = psd_pkg::DIVW'(1) << (psd_pkg::QW - 1);
    end else if (dot_q > len2_q) begin
      div_w[0].ctx.code = psd_pkg::CASE_END;
      div_w[0].rem      = psd_pkg::DIVW'(1) << (psd_pkg::QW - 1);
      div_w[0].ds       = psd_pkg::DIVW'(1) << (psd_pkg::QW - 1);
    end else begin
      div_w[0].ctx.code = psd_pkg::CASE_INTERIOR;
      div_w[0].rem      = (psd_pkg::DIVW'(dot_q) << 17) + psd_pkg::DIVW'(len2_q);
      div_w[0].ds       = psd_pkg::DIVW'(len2_q) << 17;
    end
  end
  assign div_v[0]  = v3_q;
  assign div_r[DC] = r4;

  // Divider chain for the rounded projection parameter.
  for (genvar k = 0; k < DC; k++) begin : g_div
    psd_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_v[k]),
      .in_ready_o  (div_r[k]),
      .in_word_i   (div_w[k]),
      .out_valid_o (div_v[k+1]),
      .out_ready_i (div_r[k+1]),
      .out_word_o  (div_w[k+1])
    );
  end

  // Stage four: scale the direction by the parameter.
  always_ff @(posedge clk_i) begin
    if (r4) begin
      c4_q  <= div_w[DC].ctx;
      prx_q <= 35'(div_w[DC].ctx.dx) * 35'($signed({1'b0, div_w[DC].q}));
      pry_q <= 35'(div_w[DC].ctx.dy) * 35'($signed({1'b0, div_w[DC].q}));
    end
  end

  // Stage five: round and offset from the start point.
  assign sumx = 36'(prx_q) + 36'sd128;
  assign sumy = 36'(pry_q) + 36'sd128;
  always_ff @(posedge clk_i) begin
    if (r5) begin
      c5_q  <= c4_q;
      nxf_q <= (26'(c4_q.sx) <<< 8) + 26'(sumx >>> 8);
      nyf_q <= (26'(c4_q.sy) <<< 8) + 26'(sumy >>> 8);
    end
  end

  // Stage six: error vector from the nearest point to the query.
  always_ff @(posedge clk_i) begin
    if (r6) begin
      res6_q.nx   <= nxf_q[psd_pkg::NW-1:0];
      res6_q.ny   <= nyf_q[psd_pkg::NW-1:0];
      res6_q.code <= c5_q.code;
      rx_q        <= (27'(c5_q.px) <<< 8) - 27'(nxf_q);
      ry_q        <= (27'(c5_q.py) <<< 8) - 27'(nyf_q);
    end
  end

  // Stage seven: squares of the error components.
  always_ff @(posedge clk_i) begin
    if (r7) begin
      res7_q <= res6_q;
      sqx_q  <= rx_q * rx_q;
      sqy_q  <= ry_q * ry_q;
    end
  end

  // Stage eight: squared distance.
  always_ff @(posedge clk_i) begin
    if (r8) begin
      res8_q <= res7_q;
      sq_q   <= sqx_q[49:0] + sqy_q[49:0];
    end
  end

  always_comb begin
    sq_w[0]      = '0;
    sq_w[0].n    = psd_pkg::SQW'(sq_q);
    sq_w[0].root = '0;
    sq_w[0].bitv = psd_pkg::SQW'(1) << psd_pkg::SQ_TOP;
    sq_w[0].res  = res8_q;
  end
  assign sq_v[0]  = v8_q;
  assign sq_r[SC] = out_o.ready;

  // Square root chain for the distance.
  for (genvar k = 0; k < SC; k++) begin : g_sqrt
    psd_sqrt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (sq_v[k]),
      .in_ready_o  (sq_r[k]),
      .in_word_i   (sq_w[k]),
      .out_valid_o (sq_v[k+1]),
      .out_ready_i (sq_r[k+1]),
      .out_word_o  (sq_w[k+1])
    );
  end

  // Result word.
  assign out_o.valid     = sq_v[SC];
  assign out_o.nearest_x = sq_w[SC].res.nx;
  assign out_o.nearest_y = sq_w[SC].res.ny;
  assign out_o.distance  = sq_w[SC].root[psd_pkg::DISTW-1:0];
  assign out_o.case_code = sq_w[SC].res.code;

  // With no result waiting the whole chain can take a word.
  `PSD_ASSERT(a_idle_ready, clk_i, rst_ni, !out_o.valid |-> in_i.ready)
  // A stalled output keeps the last cell full on the next edge.
  `PSD_ASSERT(a_out_hold, clk_i, rst_ni, (out_o.valid && !out_o.ready) |=> out_o.valid)

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the point segment distance core. Query words are sent with
// random gaps, results are taken with random stalls, and every result word
// is checked field by field against a predictor of the nearest point.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LATENCY   = 50;
  localparam int MAX_CYCLE = 400000;

  typedef struct packed {
    logic signed [psd_pkg::NW-1:0] nx;
    logic signed [psd_pkg::NW-1:0] ny;
    logic [psd_pkg::DISTW-1:0]     dst;
    logic [1:0]                    code;
  } near_t;

  logic clk_i;
  logic rst_ni;
  int   cycle_cnt;
  int   err_cnt;
  int   out_wait;
  bit   stall_en;
  near_t near_q[$];

  psd_in_if  in_ch();
  psd_out_if out_ch();

  point_segment_distance_core u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Integer square root, truncated.
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned rt;
    longint unsigned b;
    rt = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= rt + b) begin
        n = n - (rt + b);
        rt = (rt >> 1) + b;
      end else begin
        rt = rt >> 1;
      end
      b = b >> 2;
    end
    return rt;
  endfunction

  // Predict the nearest point, distance and case of one query.
  function automatic near_t nearest_of(input logic signed [15:0] sx, sy, ex, ey, px, py);
    longint dx, dy, len2, dot, t16, nx, ny, rx, ry, a, b;
    near_t r;
    dx = longint'(ex) - sx;
    dy = longint'(ey) - sy;
    len2 = dx * dx + dy * dy;
    dot = (longint'(px) - sx) * dx + (longint'(py) - sy) * dy;
    if (len2 == 0 || dot < 0) begin
      nx = longint'(sx) * 256;
      ny = longint'(sy) * 256;
      r.code = (len2 == 0) ? psd_pkg::CASE_DEGEN : psd_pkg::CASE_START;
    end else if (dot > len2) begin
      nx = longint'(ex) * 256;
      ny = longint'(ey) * 256;
      r.code = psd_pkg::CASE_END;
    end else begin
      t16 = (dot * 131072 + len2) / (2 * len2);
      // Arithmetic shift floors for negative values.
      a = (dx * t16 + 128) >>> 8;
      b = (dy * t16 + 128) >>> 8;
      nx = longint'(sx) * 256 + a;
      ny = longint'(sy) * 256 + b;
      r.code = psd_pkg::CASE_INTERIOR;
    end
    rx = longint'(px) * 256 - nx;
    ry = longint'(py) * 256 - ny;
    r.nx = nx[psd_pkg::NW-1:0];
    r.ny = ny[psd_pkg::NW-1:0];
    r.dst = psd_pkg::DISTW'(root_floor(longint'(rx * rx) + longint'(ry * ry)));
    return r;
  endfunction

  // Send one query word after a random gap.
  task automatic send_query(input logic [15:0] sx, sy, ex, ey, px, py);
    int gap;
    gap = stall_en ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.start_x <= sx;
    in_ch.start_y <= sy;
    in_ch.end_x   <= ex;
    in_ch.end_y   <= ey;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    do @(posedge clk_i); while (!in_ch.ready);
    near_q.push_back(nearest_of(sx, sy, ex, ey, px, py));
  endtask

  // Result stalls and checking.
  always @(posedge clk_i) begin
    near_t e;
    if (out_ch.valid && out_ch.ready) begin
      if (near_q.size() == 0) begin
        $display("%0t: unexpected result word", $time);
        err_cnt++;
      end else begin
        e = near_q.pop_front();
        if (out_ch.nearest_x !== e.nx) begin
          $display("%0t: nearest_x exp %0d got %0d", $time, e.nx, out_ch.nearest_x);
          err_cnt++;
        end
        if (out_ch.nearest_y !== e.ny) begin
          $display("%0t: nearest_y exp %0d got %0d", $time, e.ny, out_ch.nearest_y);
          err_cnt++;
        end
        if (out_ch.distance !== e.dst) begin
          $display("%0t: distance exp %0d got %0d", $time, e.dst, out_ch.distance);
          err_cnt++;
        end
        if (out_ch.case_code !== e.code) begin
          $display("%0t: case_code exp %0d got %0d", $time, e.code, out_ch.case_code);
          err_cnt++;
        end
      end
      // Draw the wait before the next result word is taken.
      out_wait = stall_en ? $urandom_range(0, 19) : 0;
    end else if (out_ch.valid && out_wait > 0) begin
      out_wait--;
    end
    out_ch.ready <= (out_wait == 0);
  end

  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: rnd_coord = 16'($urandom);
      1: rnd_coord = 16'($signed($urandom_range(0, 40)) - 20);
      2: rnd_coord = $urandom_range(0, 1) ? 16'(16'h7fff - $urandom_range(0, 3))
                                          : 16'(16'h8000 + $urandom_range(0, 3));
      default: rnd_coord = 16'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (near_q.size() != 0) @(posedge clk_i);
  endtask

  // Extremes, every case, and the projection landing exactly on an end.
  task automatic test_directed();
    send_query(16'sd5, 16'sd5, 16'sd5, 16'sd5, -16'sd3, 16'sd9);
    send_query(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_query(16'sd0, 16'sd0, 16'sd10, 16'sd0, -16'sd4, 16'sd3);
    send_query(16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd14, -16'sd3);
    send_query(16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd3, 16'sd7);
    send_query(16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd7);
    send_query(16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd10, -16'sd7);
    send_query(16'sd1, 16'sd2, 16'sd4, 16'sd9, 16'sd7, -16'sd2);
    send_query(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
    send_query(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
    send_query(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
    send_query(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_query(16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h1234, 16'hedcb);
    send_query(16'sd0, 16'sd0, 16'sd3, 16'sd7, -16'sd5, 16'sd2);
  endtask

  // Random queries, with one pause until all results are back.
  task automatic test_random();
    logic [15:0] sx, sy;
    for (int i = 0; i < 1000; i++) begin
      if (i == 500) wait_drain();
      stall_en = (i % 200) >= 40;
      sx = rnd_coord();
      sy = rnd_coord();
      if ($urandom_range(0, 15) == 0) begin
        send_query(sx, sy, sx, sy, rnd_coord(), rnd_coord());
      end else begin
        send_query(sx, sy, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
      end
    end
    stall_en = 1'b1;
  endtask

  initial begin
    cycle_cnt = 0;
    err_cnt = 0;
    out_wait = 0;
    stall_en = 1'b1;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    in_ch.end_x = '0;
    in_ch.end_y = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    wait_drain();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (err_cnt == 0 && near_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
